[design/pim_pkg.sv]
package pim_pkg;

  localparam int PRIO_W      = 8;
  localparam int ID_W        = 5;
  localparam int NEST_W      = 8;
  localparam int PRIO_LEVELS = 256;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_TRYLOCK = 2'd1,
    OP_UNLOCK  = 2'd2
  } op_e_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NESTED     = 3'd1,
    ST_BUSY       = 3'd2,
    ST_IN_IRQ     = 3'd3,
    ST_NOT_HOLDER = 3'd4,
    ST_QUEUED     = 3'd5,
    ST_QUEUE_FULL = 3'd6,
    ST_NEST_OVF   = 3'd7
  } status_e_t;

  // what the wait queue cells do: hold, insert or pop
  typedef enum logic [1:0] {
    QC_HOLD   = 2'd0,
    QC_INSERT = 2'd1,
    QC_POP    = 2'd2
  } qcmd_e_t;

  typedef struct packed {
    qcmd_e_t           cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } qctrl_t;

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] r;
    r = p;
    if ({1'b0, p} >= (PRIO_W+1)'(PRIO_LEVELS)) begin
      r = PRIO_W'(PRIO_LEVELS - 1);
    end
    return r;
  endfunction

endpackage

[design/pim_cell.sv]
module pim_cell import pim_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 4
) (
  input  logic              clk,
  input  qctrl_t            ctrl,
  input  logic [CNT_W-1:0]  count,
  input  logic [ID_W-1:0]   left_id,
  input  logic [PRIO_W-1:0] left_prio,
  input  logic              left_keep,
  input  logic [ID_W-1:0]   right_id,
  input  logic [PRIO_W-1:0] right_prio,
  output logic [ID_W-1:0]   cell_id,
  output logic [PRIO_W-1:0] cell_prio,
  output logic              keep
);

  // occupied and not less urgent than the newcomer: stays put on insert
  assign keep = (CNT_W'(IDX) < count) && (cell_prio <= ctrl.prio);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      QC_INSERT: begin
        if (!keep) begin
          if (left_keep) begin
            cell_id   <= ctrl.id;
            cell_prio <= ctrl.prio;
          end else begin
            cell_id   <= left_id;
            cell_prio <= left_prio;
          end
        end
      end
      QC_POP: begin
        cell_id   <= right_id;
        cell_prio <= right_prio;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/priority_inheritance_mutex.sv]
// each item is captured in the request register, then executed into the output register
// throughput: up to one item per cycle while the output is not stalled, as the next item is
//   taken in the cycle the current one executes; every item is settled in a single execute step
// the wait queue is a row of cells that shift right on a sorted insert or left on a pop
// reset (rst, synchronous): mutex free, queue empty, no item or result pending
// queue cell contents are not reset and are only read below the waiter count
module priority_inheritance_mutex import pim_pkg::*; #(
  parameter int WAIT_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   requester_id,
  input  logic [PRIO_W-1:0] requester_prio,
  input  logic              from_interrupt,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic              holder_valid,
  output logic [ID_W-1:0]   holder_now,
  output logic [PRIO_W-1:0] holder_eff_prio,
  output logic              boosted,
  output logic              handed_off,
  output logic [PRIO_W-1:0] restored_prio,
  output logic              switch_needed
);

  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  // mutex state
  logic              held_flag, held_flag_next;
  logic [ID_W-1:0]   owner_id, owner_id_next;
  logic [NEST_W-1:0] nest_depth, nest_depth_next;
  logic [PRIO_W-1:0] owner_base_prio, owner_base_prio_next;
  logic [PRIO_W-1:0] owner_eff_prio, owner_eff_prio_next;
  logic [CNT_W-1:0]  waiter_count, waiter_count_next;

  // captured item
  logic              req_valid;
  logic [1:0]        req_op;
  logic [ID_W-1:0]   req_id;
  logic [PRIO_W-1:0] req_prio;
  logic              req_irq;

  // result of the executing item
  status_e_t         res_status;
  logic              res_boosted, res_handed, res_sw;
  logic [PRIO_W-1:0] res_restored;

  logic   fire;
  logic   in_fire;
  qctrl_t qctrl;

  // queue cell row
  logic [ID_W-1:0]   q_id   [WAIT_DEPTH];
  logic [PRIO_W-1:0] q_prio [WAIT_DEPTH];
  logic              q_keep [WAIT_DEPTH];

  // execute when the output register is free or being emptied
  assign fire     = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !fire;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_fire) begin
      req_valid <= 1'b1;
    end else if (fire) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op   <= op;
      req_id   <= requester_id;
      req_prio <= clamp_prio(requester_prio);
      req_irq  <= from_interrupt;
    end
  end

  // request decode and next state
  always_comb begin
    held_flag_next       = held_flag;
    owner_id_next        = owner_id;
    nest_depth_next      = nest_depth;
    owner_base_prio_next = owner_base_prio;
    owner_eff_prio_next  = owner_eff_prio;
    waiter_count_next    = waiter_count;
    res_status           = ST_OK;
    res_boosted          = 1'b0;
    res_handed           = 1'b0;
    res_restored         = '0;
    res_sw               = 1'b0;
    qctrl.cmd            = QC_HOLD;
    qctrl.id             = req_id;
    qctrl.prio           = req_prio;

    unique case (req_op) inside
      OP_LOCK, OP_TRYLOCK: begin
        if (req_irq) begin
          res_status = ST_IN_IRQ;
        end else if (!held_flag) begin
          held_flag_next       = 1'b1;
          owner_id_next        = req_id;
          nest_depth_next      = NEST_W'(1);
          owner_base_prio_next = req_prio;
          owner_eff_prio_next  = req_prio;
        end else if (owner_id == req_id) begin
          if (nest_depth == {NEST_W{1'b1}}) begin
            res_status = ST_NEST_OVF;
          end else begin
            nest_depth_next = nest_depth + NEST_W'(1);
            res_status      = ST_NESTED;
          end
        end else if (req_op == OP_TRYLOCK) begin
          res_status = ST_BUSY;
        end else if (waiter_count >= CNT_W'(WAIT_DEPTH)) begin
          res_status = ST_QUEUE_FULL;
        end else begin
          // inherit the waiter's priority if it is more urgent
          if (owner_eff_prio > req_prio) begin
            owner_eff_prio_next = req_prio;
            res_boosted         = 1'b1;
          end
          qctrl.cmd         = QC_INSERT;
          waiter_count_next = waiter_count + CNT_W'(1);
          res_status        = ST_QUEUED;
        end
      end
      OP_UNLOCK: begin
        if (!held_flag || owner_id != req_id) begin
          res_status = ST_NOT_HOLDER;
        end else if (nest_depth != NEST_W'(1)) begin
          nest_depth_next = nest_depth - NEST_W'(1);
          res_restored    = owner_eff_prio;
        end else begin
          res_restored = owner_base_prio;
          if (waiter_count != '0) begin
            // hand over to the head of the queue
            owner_id_next        = q_id[0];
            owner_base_prio_next = q_prio[0];
            owner_eff_prio_next  = q_prio[0];
            nest_depth_next      = NEST_W'(1);
            waiter_count_next    = waiter_count - CNT_W'(1);
            qctrl.cmd            = QC_POP;
            res_handed           = 1'b1;
            res_sw               = owner_base_prio > q_prio[0];
          end else begin
            held_flag_next       = 1'b0;
            owner_id_next        = '0;
            nest_depth_next      = '0;
            owner_base_prio_next = '0;
            owner_eff_prio_next  = '0;
          end
        end
      end
      default: begin
      end
    endcase

    // no queue movement unless the item really executes
    if (!fire) begin
      qctrl.cmd = QC_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_flag       <= 1'b0;
      owner_id        <= '0;
      nest_depth      <= '0;
      owner_base_prio <= '0;
      owner_eff_prio  <= '0;
      waiter_count    <= '0;
    end else if (fire) begin
      held_flag       <= held_flag_next;
      owner_id        <= owner_id_next;
      nest_depth      <= nest_depth_next;
      owner_base_prio <= owner_base_prio_next;
      owner_eff_prio  <= owner_eff_prio_next;
      waiter_count    <= waiter_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status          <= res_status;
      holder_valid    <= held_flag_next;
      holder_now      <= owner_id_next;
      holder_eff_prio <= owner_eff_prio_next;
      boosted         <= res_boosted;
      handed_off      <= res_handed;
      restored_prio   <= res_restored;
      switch_needed   <= res_sw;
    end
  end

  // wait queue, most urgent waiter in cell 0
  for (genvar g = 0; g < WAIT_DEPTH; g++) begin : g_cell
    logic [ID_W-1:0]   l_id, r_id;
    logic [PRIO_W-1:0] l_prio, r_prio;
    logic              l_keep;

    if (g == 0) begin : g_first
      assign l_id   = '0;
      assign l_prio = '0;
      assign l_keep = 1'b1;
    end else begin : g_inner
      assign l_id   = q_id[g-1];
      assign l_prio = q_prio[g-1];
      assign l_keep = q_keep[g-1];
    end

    if (g == WAIT_DEPTH - 1) begin : g_last
      assign r_id   = q_id[g];
      assign r_prio = q_prio[g];
    end else begin : g_mid
      assign r_id   = q_id[g+1];
      assign r_prio = q_prio[g+1];
    end

    pim_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (qctrl),
      .count      (waiter_count),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .left_keep  (l_keep),
      .right_id   (r_id),
      .right_prio (r_prio),
      .cell_id    (q_id[g]),
      .cell_prio  (q_prio[g]),
      .keep       (q_keep[g])
    );
  end

endmodule

[bench/pim_checker.sv]
module pim_checker import pim_pkg::*; #(
  parameter int WAIT_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   requester_id,
  input  logic [PRIO_W-1:0] requester_prio,
  input  logic              from_interrupt,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        status,
  input  logic              holder_valid,
  input  logic [ID_W-1:0]   holder_now,
  input  logic [PRIO_W-1:0] holder_eff_prio,
  input  logic              boosted,
  input  logic              handed_off,
  input  logic [PRIO_W-1:0] restored_prio,
  input  logic              switch_needed,
  output int                fail_count,
  output int                pending,
  output logic              hint_held,
  output logic [ID_W-1:0]   hint_holder
);

  localparam int NEST_MAX = 255;

  typedef struct packed {
    logic [2:0]        status;
    logic              holder_valid;
    logic [ID_W-1:0]   holder_now;
    logic [PRIO_W-1:0] holder_eff_prio;
    logic              boosted;
    logic              handed_off;
    logic [PRIO_W-1:0] restored_prio;
    logic              switch_needed;
  } mutex_answer_t;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } waiter_t;

  // shadow of the mutex
  logic              held;
  logic [ID_W-1:0]   owner;
  logic [NEST_W-1:0] depth;
  logic [PRIO_W-1:0] base_prio;
  logic [PRIO_W-1:0] eff_prio;
  waiter_t           wait_line[$];

  mutex_answer_t     answers_due[$];
  int                errs = 0;
  int                n_results = 0;

  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
    if (int'(p) >= PRIO_LEVELS) begin
      return PRIO_W'(PRIO_LEVELS - 1);
    end
    return p;
  endfunction

  task automatic apply_request(input logic [1:0] o, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] p_in, input logic irq,
                               output mutex_answer_t a);
    logic [PRIO_W-1:0] p;
    logic [PRIO_W-1:0] rel;
    int                pos;
    waiter_t           w;
    p = sat_prio(p_in);
    a = '0;
    a.status = ST_OK;
    if (o == OP_LOCK || o == OP_TRYLOCK) begin
      if (irq) begin
        a.status = ST_IN_IRQ;
      end else if (!held) begin
        held      = 1'b1;
        owner     = id;
        depth     = NEST_W'(1);
        base_prio = p;
        eff_prio  = p;
      end else if (owner == id) begin
        if (int'(depth) >= NEST_MAX) begin
          a.status = ST_NEST_OVF;
        end else begin
          depth    = depth + 1'b1;
          a.status = ST_NESTED;
        end
      end else if (o == OP_TRYLOCK) begin
        a.status = ST_BUSY;
      end else if (wait_line.size() >= WAIT_DEPTH) begin
        a.status = ST_QUEUE_FULL;
      end else begin
        if (eff_prio > p) begin
          eff_prio  = p;
          a.boosted = 1'b1;
        end
        // sorted insert, behind waiters of equal priority
        pos = wait_line.size();
        while (pos > 0 && wait_line[pos-1].prio > p) pos--;
        w.id   = id;
        w.prio = p;
        wait_line.insert(pos, w);
        a.status = ST_QUEUED;
      end
    end else if (o == OP_UNLOCK) begin
      if (!held || owner != id) begin
        a.status = ST_NOT_HOLDER;
      end else begin
        depth = depth - 1'b1;
        if (depth != 0) begin
          a.restored_prio = eff_prio;
        end else begin
          rel             = base_prio;
          a.restored_prio = rel;
          if (wait_line.size() != 0) begin
            w               = wait_line.pop_front();
            owner           = w.id;
            base_prio       = w.prio;
            eff_prio        = w.prio;
            depth           = NEST_W'(1);
            a.handed_off    = 1'b1;
            a.switch_needed = (rel > w.prio);
          end else begin
            held      = 1'b0;
            owner     = '0;
            base_prio = '0;
            eff_prio  = '0;
          end
        end
      end
    end
    a.holder_valid    = held;
    a.holder_now      = held ? owner : '0;
    a.holder_eff_prio = held ? eff_prio : '0;
  endtask

  always @(posedge clk) begin
    mutex_answer_t fresh;
    mutex_answer_t due;
    mutex_answer_t got;
    if (rst) begin
      held      = 1'b0;
      owner     = '0;
      depth     = '0;
      base_prio = '0;
      eff_prio  = '0;
      wait_line.delete();
      answers_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(op, requester_id, requester_prio, from_interrupt, fresh);
        answers_due.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        got = {status, holder_valid, holder_now, holder_eff_prio, boosted, handed_off,
               restored_prio, switch_needed};
        if (answers_due.size() == 0) begin
          if (errs < 10) begin
            $display("unexpected result %0d: st=%0d hv=%0b id=%0d ep=%0d", n_results,
                     got.status, got.holder_valid, got.holder_now, got.holder_eff_prio);
          end
          errs++;
        end else begin
          due = answers_due.pop_front();
          if (got !== due) begin
            if (errs < 10) begin
              $display("mismatch at result %0d", n_results);
              $display("  exp st=%0d hv=%0b id=%0d ep=%0d bo=%0b ho=%0b rp=%0d sw=%0b",
                       due.status, due.holder_valid, due.holder_now,
                       due.holder_eff_prio, due.boosted, due.handed_off, due.restored_prio,
                       due.switch_needed);
              $display("  got st=%0d hv=%0b id=%0d ep=%0d bo=%0b ho=%0b rp=%0d sw=%0b",
                       got.status, got.holder_valid, got.holder_now, got.holder_eff_prio,
                       got.boosted, got.handed_off, got.restored_prio, got.switch_needed);
            end
            errs++;
          end
        end
        n_results++;
      end
    end
    fail_count  <= errs;
    pending     <= answers_due.size();
    hint_held   <= held;
    hint_holder <= owner;
  end

endmodule

[bench/priority_inheritance_mutex_tb.sv]
module priority_inheritance_mutex_tb;
  import pim_pkg::*;

  // op code the block leaves unused; it must answer ok with the current holder
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PER_PHASE = 260;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = '0;
  logic [ID_W-1:0]   requester_id = '0;
  logic [PRIO_W-1:0] requester_prio = '0;
  logic              from_interrupt = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic              holder_valid;
  logic [ID_W-1:0]   holder_now;
  logic [PRIO_W-1:0] holder_eff_prio;
  logic              boosted;
  logic              handed_off;
  logic [PRIO_W-1:0] restored_prio;
  logic              switch_needed;

  // from the checker: failure count, results still owed, and a hint of who holds
  int                fail_count;
  int                pending;
  logic              hint_held;
  logic [ID_W-1:0]   hint_holder;

  // idling knobs, in percent of cycles
  int gap_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, requested here and counted out by the receiver process
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // small pools so that the same tasks meet again: nesting, queueing, duplicates
  logic [ID_W-1:0]   id_pool[4];
  logic [PRIO_W-1:0] prio_pool[4];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  priority_inheritance_mutex #(.WAIT_DEPTH(8)) DUT (.*);

  pim_checker #(.WAIT_DEPTH(8)) chk (.*);

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one item, after a random gap, and wait until the block takes it
  task automatic send_item(input logic [1:0] o, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] p, input logic irq);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= o;
    requester_id   <= id;
    requester_prio <= p;
    from_interrupt <= irq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < 4; i++) begin
      id_pool[i]   = ID_W'($urandom_range(31));
      prio_pool[i] = PRIO_W'($urandom_range(255));
    end
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    case ($urandom_range(3)) inside
      0, 1:    return prio_pool[$urandom_range(3)];
      2:       return PRIO_W'($urandom_range(255));
      default: return $urandom_range(1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // mostly sensible traffic: the holder unlocks, pool tasks lock; the rest is
  // interrupt context, the unused op and fully random noise
  task automatic send_random();
    int                r;
    logic [1:0]        o;
    logic [ID_W-1:0]   id;
    logic              irq;
    r   = $urandom_range(99);
    id  = id_pool[$urandom_range(3)];
    irq = 1'b0;
    if (r < 38 && hint_held) begin
      o   = OP_UNLOCK;
      id  = hint_holder;
      irq = ($urandom_range(4) == 0);
    end else if (r < 72) begin
      o = OP_LOCK;
    end else if (r < 80) begin
      o = OP_TRYLOCK;
    end else if (r < 85) begin
      o = OP_UNLOCK;
    end else if (r < 90) begin
      o   = $urandom_range(1) ? OP_LOCK : OP_TRYLOCK;
      irq = 1'b1;
    end else if (r < 94) begin
      o   = OP_UNUSED;
      irq = 1'(($urandom_range(1)));
    end else begin
      o   = 2'($urandom_range(3));
      id  = ID_W'($urandom_range(31));
      irq = 1'(($urandom_range(1)));
    end
    send_item(o, id, pick_prio(), irq);
  endtask

  int phase_gap[4]   = '{0, 57, 0, 16};
  int phase_stall[4] = '{0, 0, 57, 16};

  initial begin
    logic [ID_W-1:0]   nest_id;
    logic [PRIO_W-1:0] nest_prio;
    int                guard;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling
    send_item(OP_UNLOCK, 5'd0, 8'd0, 1'b0);      // unlock of a free mutex
    send_item(OP_UNUSED, 5'd7, 8'd9, 1'b0);      // unused op on a free mutex
    send_item(OP_LOCK, 5'd5, 8'd10, 1'b1);       // interrupt lock refused
    send_item(OP_TRYLOCK, 5'd5, 8'd10, 1'b1);    // interrupt trylock refused
    send_item(OP_LOCK, 5'd31, 8'd255, 1'b0);     // free mutex granted
    send_item(OP_TRYLOCK, 5'd31, 8'd0, 1'b0);    // holder nests
    send_item(OP_TRYLOCK, 5'd2, 8'd0, 1'b0);     // busy
    send_item(OP_LOCK, 5'd3, 8'd100, 1'b0);      // queued, holder boosted
    send_item(OP_LOCK, 5'd4, 8'd100, 1'b0);      // equal priority goes behind
    send_item(OP_LOCK, 5'd3, 8'd100, 1'b0);      // duplicate waiter
    send_item(OP_LOCK, 5'd5, 8'd0, 1'b0);        // boost to most urgent
    send_item(OP_UNLOCK, 5'd2, 8'd0, 1'b0);      // not the holder
    send_item(OP_UNLOCK, 5'd31, 8'd255, 1'b1);   // nested unlock, interrupt flag ignored
    send_item(OP_UNUSED, 5'd31, 8'd255, 1'b1);   // unused op with a holder
    send_item(OP_LOCK, 5'd6, 8'd255, 1'b0);
    send_item(OP_LOCK, 5'd7, 8'd50, 1'b0);
    send_item(OP_LOCK, 5'd8, 8'd1, 1'b0);
    send_item(OP_LOCK, 5'd9, 8'd200, 1'b0);      // queue now full
    send_item(OP_LOCK, 5'd10, 8'd0, 1'b0);       // queue full, no boost
    send_item(OP_TRYLOCK, 5'd10, 8'd0, 1'b0);    // trylock still only busy
    send_item(OP_UNLOCK, 5'd31, 8'd0, 1'b0);     // handoff with switch
    send_item(OP_UNLOCK, 5'd5, 8'd0, 1'b0);      // handoff, no switch
    send_item(OP_UNLOCK, 5'd8, 8'd0, 1'b0);

    // random phases under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      refresh_pools();
      if (ph == 0) begin
        // long receiver hold-off while items keep coming, so the block backs up
        hold_asked++;
        for (int i = 0; i < 40; i++) send_random();
      end
      for (int i = 0; i < RAND_PER_PHASE; i++) send_random();
    end

    // drain the mutex, then walk one task up to the nesting limit and back
    gap_pct   = 16;
    stall_pct = 16;
    guard     = 0;
    while (hint_held && guard < 3000) begin
      send_item(OP_UNLOCK, hint_holder, 8'd0, 1'b0);
      guard++;
    end
    nest_id   = ID_W'($urandom_range(31));
    nest_prio = PRIO_W'($urandom_range(255));
    for (int i = 0; i < 255; i++) send_item(OP_LOCK, nest_id, nest_prio, 1'b0);
    send_item(OP_LOCK, nest_id, nest_prio, 1'b0);     // nest overflow
    send_item(OP_TRYLOCK, nest_id, nest_prio, 1'b0);  // nest overflow by trylock
    for (int i = 0; i < 255; i++) send_item(OP_UNLOCK, nest_id, nest_prio, 1'b0);
    in_valid <= 1'b0;

    // let every owed result arrive, then a margin for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("** priority_inheritance_mutex: PASSED **");
    end else begin
      $display("** priority_inheritance_mutex: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** priority_inheritance_mutex: FAILED **");
    $finish;
  end

endmodule
